FILE: rtl/rosi_pkg.sv
// Shared types, constants and helpers for the ray versus oriented box test.
`timescale 1ns / 1ps
package rosi_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X    = 3'd3;
    localparam logic [2:0] REG_DIR_Y    = 3'd4;
    localparam logic [2:0] REG_DIR_Z    = 3'd5;

    // Reset value of the direction x register: 1.0 in Q16.16.
    localparam logic [31:0] DIR_X_RESET = 32'h0001_0000;

    // Field widths.
    localparam int VAL_W  = 32;   // Q16.16 values
    localparam int COL_W  = 48;   // three packed Q2.14 rotation entries
    localparam int ROT_W  = 16;   // one Q2.14 entry
    localparam int EXT_W  = 31;   // full box size
    localparam int OFF_W  = 33;   // origin minus center
    localparam int LO_W   = 37;   // local origin, Q16.16 kept wide
    localparam int LD_W   = 36;   // local direction, Q16.16 kept wide
    localparam int NUM_W  = 39;   // slab numerator (+-ext - 2*lo)
    localparam int DEN_W  = 36;   // divisor magnitude
    localparam int DVD_W  = 54;   // numerator magnitude times 2^15
    localparam int Q_W    = 32;   // quotient bits

    // Divider pipeline: quotient bits retired per stage and stage count.
    localparam int STEP_BITS = 2;
    localparam int STEPS     = Q_W / STEP_BITS;

    // Pipeline stage indexes.
    localparam int ST_A   = 0;               // input register, offsets
    localparam int ST_B   = 1;               // rotation products
    localparam int ST_C   = 2;               // rotation sums, rounding
    localparam int ST_D   = 3;               // slab numerators
    localparam int ST_DIV = 4;               // divider range check
    localparam int ST_F   = ST_DIV + STEPS + 1;  // saturation, near and far
    localparam int ST_G   = ST_F + 1;        // interval reduction
    localparam int ST_H   = ST_G + 1;        // output register
    localparam int NST    = ST_H + 1;

    localparam logic signed [VAL_W-1:0] T_LOW  = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] T_HIGH = 32'sh7FFF_FFFF;

    // Per-axis flags that ride alongside the divider.
    typedef struct packed {
        logic [2:0] par;   // local direction is zero
        logic [2:0] rej;   // parallel and origin outside the slab
    } t_axis_flags;

    // Apply sign and saturate a magnitude quotient to the Q16.16 range.
    function automatic logic signed [VAL_W-1:0] sat_t(
        input logic [Q_W-1:0] q,
        input logic           ovf,
        input logic           neg
    );
        logic big;
        big = ovf | q[Q_W-1];
        if (neg) begin
            sat_t = big ? T_LOW : -$signed(q);
        end else begin
            sat_t = big ? T_HIGH : $signed(q);
        end
    endfunction

endpackage

FILE: rtl/rosi_rotate.sv
// Rotates the origin offset and the ray direction onto one box axis (two stages).
`timescale 1ns / 1ps
module rosi_rotate (
    input  logic                              i_clk,
    input  logic [1:0]                        i_en,     // products, sums
    input  logic signed [rosi_pkg::OFF_W-1:0] i_off_x,
    input  logic signed [rosi_pkg::OFF_W-1:0] i_off_y,
    input  logic signed [rosi_pkg::OFF_W-1:0] i_off_z,
    input  logic signed [rosi_pkg::VAL_W-1:0] i_dir_x,
    input  logic signed [rosi_pkg::VAL_W-1:0] i_dir_y,
    input  logic signed [rosi_pkg::VAL_W-1:0] i_dir_z,
    input  logic [rosi_pkg::COL_W-1:0]        i_col,
    output logic signed [rosi_pkg::LO_W-1:0]  o_lo,
    output logic signed [rosi_pkg::LD_W-1:0]  o_ld
);

    localparam int PO_W = rosi_pkg::OFF_W + rosi_pkg::ROT_W;
    localparam int PD_W = rosi_pkg::VAL_W + rosi_pkg::ROT_W;
    localparam int SO_W = PO_W + 2;
    localparam int SD_W = PD_W + 2;

    logic signed [rosi_pkg::ROT_W-1:0] w_r0, w_r1, w_r2;
    logic signed [PO_W-1:0] r_po0, r_po1, r_po2;
    logic signed [PD_W-1:0] r_pd0, r_pd1, r_pd2;
    logic signed [SO_W-1:0] w_so;
    logic signed [SD_W-1:0] w_sd;
    logic signed [rosi_pkg::LO_W-1:0] r_lo;
    logic signed [rosi_pkg::LD_W-1:0] r_ld;

    assign w_r0 = $signed(i_col[15:0]);
    assign w_r1 = $signed(i_col[31:16]);
    assign w_r2 = $signed(i_col[47:32]);

    // Six products, registered.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_po0 <= i_off_x * w_r0;
            r_po1 <= i_off_y * w_r1;
            r_po2 <= i_off_z * w_r2;
            r_pd0 <= i_dir_x * w_r0;
            r_pd1 <= i_dir_y * w_r1;
            r_pd2 <= i_dir_z * w_r2;
        end
    end

    // Sum of products, round half up and drop the 14 fraction bits.
    assign w_so = SO_W'(r_po0) + SO_W'(r_po1) + SO_W'(r_po2) + SO_W'(8192);
    assign w_sd = SD_W'(r_pd0) + SD_W'(r_pd1) + SD_W'(r_pd2) + SD_W'(8192);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_lo <= w_so[SO_W-1:14];
            r_ld <= w_sd[SD_W-1:14];
        end
    end

    assign o_lo = r_lo;
    assign o_ld = r_ld;

endmodule

FILE: rtl/rosi_div.sv
// Pipelined restoring divider with range check, a few quotient bits per stage.
`timescale 1ns / 1ps
module rosi_div (
    input  logic                          i_clk,
    input  logic [rosi_pkg::STEPS:0]      i_en,       // range check, then steps
    input  logic [rosi_pkg::NUM_W-1:0]    i_num_mag,
    input  logic                          i_num_neg,
    input  logic [rosi_pkg::DEN_W-1:0]    i_den_mag,
    input  logic                          i_den_neg,
    output logic [rosi_pkg::Q_W-1:0]      o_q,
    output logic                          o_ovf,
    output logic                          o_neg
);

    localparam int DW = rosi_pkg::DEN_W;
    localparam int QW = rosi_pkg::Q_W;
    localparam int HW = rosi_pkg::DVD_W - QW;

    logic [rosi_pkg::DVD_W-1:0] w_dvd;
    logic [DW-1:0] r_rem [0:rosi_pkg::STEPS];
    logic [DW-1:0] r_den [0:rosi_pkg::STEPS];
    logic [QW-1:0] r_dvd [0:rosi_pkg::STEPS];
    logic [QW-1:0] r_q   [0:rosi_pkg::STEPS];
    logic          r_ovf [0:rosi_pkg::STEPS];
    logic          r_neg [0:rosi_pkg::STEPS];

    // Dividend is the numerator magnitude scaled by 2^15.
    assign w_dvd = {i_num_mag, 15'd0};

    // Range check: the quotient needs more than 32 bits when the high part
    // of the dividend already reaches the divisor.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= DW'(w_dvd[rosi_pkg::DVD_W-1:QW]);
            r_den[0] <= i_den_mag;
            r_dvd[0] <= w_dvd[QW-1:0];
            r_q[0]   <= '0;
            r_ovf[0] <= {{(DW-HW){1'b0}}, w_dvd[rosi_pkg::DVD_W-1:QW]} >= i_den_mag;
            r_neg[0] <= i_num_neg ^ i_den_neg;
        end
    end

    // Shift-subtract steps.
    for (genvar k = 1; k <= rosi_pkg::STEPS; k++) begin : g_step
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_dvd;
        logic [QW-1:0] n_q;

        always_comb begin
            logic [DW:0] t;
            n_rem = r_rem[k-1];
            n_dvd = r_dvd[k-1];
            n_q   = r_q[k-1];
            for (int j = 0; j < rosi_pkg::STEP_BITS; j++) begin
                t     = {n_rem, n_dvd[QW-1]};
                n_dvd = {n_dvd[QW-2:0], 1'b0};
                if (t >= {1'b0, r_den[k-1]}) begin
                    n_rem = DW'(t - {1'b0, r_den[k-1]});
                    n_q   = {n_q[QW-2:0], 1'b1};
                end else begin
                    n_rem = t[DW-1:0];
                    n_q   = {n_q[QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k] <= n_rem;
                r_den[k] <= r_den[k-1];
                r_dvd[k] <= n_dvd;
                r_q[k]   <= n_q;
                r_ovf[k] <= r_ovf[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    assign o_q   = r_q[rosi_pkg::STEPS];
    assign o_ovf = r_ovf[rosi_pkg::STEPS];
    assign o_neg = r_neg[rosi_pkg::STEPS];

endmodule

FILE: rtl/ray_obb_slab_intersect.sv
// Top level: ray versus oriented box test by the slab method, one box per beat.
`timescale 1ns / 1ps
// Usage:
//   The ray origin and direction sit in six configuration registers written
//   through i_cfg_we / i_cfg_idx / i_cfg_wdata (origin x,y,z then direction
//   x,y,z, Q16.16). Write them only while no box is in flight.
//   Each input beat on s_axis carries one box; each output beat on m_axis
//   carries the hit flag and the entry distance for that box, in order.
//   The 17-stage divider that forms the slab distances (16 stages of
//   two quotient bits plus a range check) and seven stages around it
//   make up the pipeline from the input beat to the output register.
//   Throughput is one box per cycle while the receiver keeps m_axis_tready high.
//   Every stage carries a valid bit and moves when it is empty or when the
//   stage after it moves, so bubbles close up while the receiver stalls and
//   s_axis_tready drops only once the whole pipeline is full. A stalled
//   output beat holds its data.
//   A synchronous reset clears all valid bits and restores the ray to the
//   origin pointing along +x.
module ray_obb_slab_intersect (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration writes.
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_wdata,
    // Box beats in.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // From bit 0: center_x[31:0], center_y[63:32], center_z[95:64],
    // axis_local_x[143:96], axis_local_y[191:144], axis_local_z[239:192],
    // extent_x[270:240], extent_y[301:271], extent_z[332:302], zero pad.
    input  logic [335:0] s_axis_tdata,
    // Result beats out.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // From bit 0: hit[0], entry_distance[32:1], zero pad.
    output logic [39:0]  m_axis_tdata
);

    localparam int VW = rosi_pkg::VAL_W;
    localparam int NST = rosi_pkg::NST;

    // Configuration registers.
    logic signed [VW-1:0] r_org_x, r_org_y, r_org_z;
    logic signed [VW-1:0] r_dir_x, r_dir_y, r_dir_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
            r_dir_x <= rosi_pkg::DIR_X_RESET;
            r_dir_y <= '0;
            r_dir_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rosi_pkg::REG_ORIGIN_X: r_org_x <= i_cfg_wdata;
                rosi_pkg::REG_ORIGIN_Y: r_org_y <= i_cfg_wdata;
                rosi_pkg::REG_ORIGIN_Z: r_org_z <= i_cfg_wdata;
                rosi_pkg::REG_DIR_X:    r_dir_x <= i_cfg_wdata;
                rosi_pkg::REG_DIR_Y:    r_dir_y <= i_cfg_wdata;
                rosi_pkg::REG_DIR_Z:    r_dir_z <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage valid bits and move enables.
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;

    always_comb begin
        w_en[NST-1] = !r_vld[NST-1] || m_axis_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = w_en[0];

    // Stage A: register the box and form origin minus center.
    logic signed [rosi_pkg::OFF_W-1:0] r_a_off [3];
    logic [rosi_pkg::COL_W-1:0]        r_a_col [3];
    logic [rosi_pkg::EXT_W-1:0]        r_a_ext [3];

    always_ff @(posedge i_clk) begin
        if (w_en[rosi_pkg::ST_A]) begin
            r_a_off[0] <= rosi_pkg::OFF_W'(r_org_x) - rosi_pkg::OFF_W'($signed(s_axis_tdata[31:0]));
            r_a_off[1] <= rosi_pkg::OFF_W'(r_org_y) - rosi_pkg::OFF_W'($signed(s_axis_tdata[63:32]));
            r_a_off[2] <= rosi_pkg::OFF_W'(r_org_z) - rosi_pkg::OFF_W'($signed(s_axis_tdata[95:64]));
            r_a_col[0] <= s_axis_tdata[143:96];
            r_a_col[1] <= s_axis_tdata[191:144];
            r_a_col[2] <= s_axis_tdata[239:192];
            r_a_ext[0] <= s_axis_tdata[270:240];
            r_a_ext[1] <= s_axis_tdata[301:271];
            r_a_ext[2] <= s_axis_tdata[332:302];
        end
    end

    // Stages B and C: rotation into the box frame; extents ride along.
    logic signed [rosi_pkg::LO_W-1:0] w_lo [3];
    logic signed [rosi_pkg::LD_W-1:0] w_ld [3];
    logic [rosi_pkg::EXT_W-1:0] r_b_ext [3];
    logic [rosi_pkg::EXT_W-1:0] r_c_ext [3];

    for (genvar a = 0; a < 3; a++) begin : g_rot
        rosi_rotate u_rot (
            .i_clk   (i_clk),
            .i_en    (w_en[rosi_pkg::ST_C:rosi_pkg::ST_B]),
            .i_off_x (r_a_off[0]),
            .i_off_y (r_a_off[1]),
            .i_off_z (r_a_off[2]),
            .i_dir_x (r_dir_x),
            .i_dir_y (r_dir_y),
            .i_dir_z (r_dir_z),
            .i_col   (r_a_col[a]),
            .o_lo    (w_lo[a]),
            .o_ld    (w_ld[a])
        );

        always_ff @(posedge i_clk) begin
            if (w_en[rosi_pkg::ST_B]) begin
                r_b_ext[a] <= r_a_ext[a];
            end
            if (w_en[rosi_pkg::ST_C]) begin
                r_c_ext[a] <= r_b_ext[a];
            end
        end
    end

    // Stage D: slab numerators, their magnitudes, and the parallel test.
    logic [rosi_pkg::NUM_W-1:0] r_d_nm1 [3];
    logic [rosi_pkg::NUM_W-1:0] r_d_nm2 [3];
    logic [2:0] r_d_ns1, r_d_ns2;
    logic [rosi_pkg::DEN_W-1:0] r_d_dm [3];
    logic [2:0] r_d_ds;
    rosi_pkg::t_axis_flags r_d_flg;

    for (genvar a = 0; a < 3; a++) begin : g_num
        logic signed [rosi_pkg::NUM_W-1:0] w_two_lo, w_ext, w_n1, w_n2, w_mag_lo;

        assign w_two_lo = rosi_pkg::NUM_W'(w_lo[a]) <<< 1;
        assign w_ext    = $signed({{(rosi_pkg::NUM_W-rosi_pkg::EXT_W){1'b0}}, r_c_ext[a]});
        assign w_n1     = -w_ext - w_two_lo;
        assign w_n2     = w_ext - w_two_lo;
        assign w_mag_lo = w_two_lo[rosi_pkg::NUM_W-1] ? -w_two_lo : w_two_lo;

        always_ff @(posedge i_clk) begin
            if (w_en[rosi_pkg::ST_D]) begin
                r_d_nm1[a]     <= w_n1[rosi_pkg::NUM_W-1] ? -w_n1 : w_n1;
                r_d_ns1[a]     <= w_n1[rosi_pkg::NUM_W-1];
                r_d_nm2[a]     <= w_n2[rosi_pkg::NUM_W-1] ? -w_n2 : w_n2;
                r_d_ns2[a]     <= w_n2[rosi_pkg::NUM_W-1];
                r_d_dm[a]      <= w_ld[a][rosi_pkg::LD_W-1] ? -w_ld[a] : w_ld[a];
                r_d_ds[a]      <= w_ld[a][rosi_pkg::LD_W-1];
                r_d_flg.par[a] <= (w_ld[a] == '0);
                r_d_flg.rej[a] <= (w_ld[a] == '0) && (w_mag_lo > w_ext);
            end
        end
    end

    // Divider stages: six slab distances; axis flags delayed alongside.
    logic [rosi_pkg::Q_W-1:0] w_q1 [3];
    logic [rosi_pkg::Q_W-1:0] w_q2 [3];
    logic [2:0] w_ovf1, w_ovf2, w_neg1, w_neg2;
    rosi_pkg::t_axis_flags r_dl_flg [0:rosi_pkg::STEPS];

    for (genvar a = 0; a < 3; a++) begin : g_div
        rosi_div u_div1 (
            .i_clk     (i_clk),
            .i_en      (w_en[rosi_pkg::ST_DIV +: rosi_pkg::STEPS + 1]),
            .i_num_mag (r_d_nm1[a]),
            .i_num_neg (r_d_ns1[a]),
            .i_den_mag (r_d_dm[a]),
            .i_den_neg (r_d_ds[a]),
            .o_q       (w_q1[a]),
            .o_ovf     (w_ovf1[a]),
            .o_neg     (w_neg1[a])
        );
        rosi_div u_div2 (
            .i_clk     (i_clk),
            .i_en      (w_en[rosi_pkg::ST_DIV +: rosi_pkg::STEPS + 1]),
            .i_num_mag (r_d_nm2[a]),
            .i_num_neg (r_d_ns2[a]),
            .i_den_mag (r_d_dm[a]),
            .i_den_neg (r_d_ds[a]),
            .o_q       (w_q2[a]),
            .o_ovf     (w_ovf2[a]),
            .o_neg     (w_neg2[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en[rosi_pkg::ST_DIV]) begin
            r_dl_flg[0] <= r_d_flg;
        end
        for (int k = 1; k <= rosi_pkg::STEPS; k++) begin
            if (w_en[rosi_pkg::ST_DIV + k]) begin
                r_dl_flg[k] <= r_dl_flg[k-1];
            end
        end
    end

    // Stage F: saturate, then order each pair into near and far.
    logic signed [VW-1:0] r_f_near [3];
    logic signed [VW-1:0] r_f_far  [3];
    logic r_f_ok;

    for (genvar a = 0; a < 3; a++) begin : g_sat
        logic signed [VW-1:0] w_t1, w_t2;

        assign w_t1 = rosi_pkg::sat_t(w_q1[a], w_ovf1[a], w_neg1[a]);
        assign w_t2 = rosi_pkg::sat_t(w_q2[a], w_ovf2[a], w_neg2[a]);

        always_ff @(posedge i_clk) begin
            if (w_en[rosi_pkg::ST_F]) begin
                if (r_dl_flg[rosi_pkg::STEPS].par[a]) begin
                    // A parallel axis leaves the interval alone.
                    r_f_near[a] <= rosi_pkg::T_LOW;
                    r_f_far[a]  <= rosi_pkg::T_HIGH;
                end else begin
                    r_f_near[a] <= (w_t1 < w_t2) ? w_t1 : w_t2;
                    r_f_far[a]  <= (w_t1 < w_t2) ? w_t2 : w_t1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[rosi_pkg::ST_F]) begin
            r_f_ok <= (r_dl_flg[rosi_pkg::STEPS].rej == '0);
        end
    end

    // Stage G: entry is the largest near, exit the smallest far.
    logic signed [VW-1:0] w_n01, w_f01;
    logic signed [VW-1:0] r_g_tmin, r_g_tmax;
    logic r_g_ok;

    assign w_n01 = (r_f_near[0] > r_f_near[1]) ? r_f_near[0] : r_f_near[1];
    assign w_f01 = (r_f_far[0] < r_f_far[1]) ? r_f_far[0] : r_f_far[1];

    always_ff @(posedge i_clk) begin
        if (w_en[rosi_pkg::ST_G]) begin
            r_g_tmin <= (w_n01 > r_f_near[2]) ? w_n01 : r_f_near[2];
            r_g_tmax <= (w_f01 < r_f_far[2]) ? w_f01 : r_f_far[2];
            r_g_ok   <= r_f_ok;
        end
    end

    // Stage H: hit decision and output register.
    logic w_hit;
    logic r_h_hit;
    logic signed [VW-1:0] r_h_dist;

    assign w_hit = r_g_ok && !r_g_tmax[VW-1] && !(r_g_tmin > r_g_tmax);

    always_ff @(posedge i_clk) begin
        if (w_en[rosi_pkg::ST_H]) begin
            r_h_hit  <= w_hit;
            r_h_dist <= w_hit ? r_g_tmin : '0;
        end
    end

    assign m_axis_tvalid = r_vld[NST-1];
    assign m_axis_tdata  = {7'd0, r_h_dist, r_h_hit};

endmodule

FILE: rtl/rosi_chk.sv
// Port-level checker for the ray versus oriented box block, bound to the top level.
`timescale 1ns / 1ps
module rosi_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // A result beat that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its data.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // A miss reports an entry distance of zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == 32'd0)
        else $error("miss with nonzero entry distance");

    // With no result waiting, the pipeline can always take a box.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with output empty");

    // Reset leaves no result offered.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind ray_obb_slab_intersect rosi_chk u_rosi_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/sv/tb_top.sv
// Testbench for the ray versus oriented box slab test with a predictor.
`timescale 1ns / 1ps
module tb_top;

    localparam int ONE      = 65536;      // 1.0 in Q16.16
    localparam int ROT_ONE  = 16384;      // 1.0 in Q2.14
    localparam int DRAIN_CY = 40;         // margin after the last result for the pipeline to empty
    localparam int HOLD_CY  = 300;

    typedef struct {
        logic [31:0] cx, cy, cz;
        logic [47:0] ax, ay, az;
        logic [30:0] ex, ey, ez;
    } t_box;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_idx = '0;
    logic [31:0]  i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [335:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;

    // Ray registers as the block should hold them: origin x,y,z then direction x,y,z.
    logic [31:0]  ray_reg [6];
    // Expected {entry_distance, hit} per box, oldest first.
    logic [32:0]  pending_hits [$];
    int           errors = 0;
    bit           quiet = 1'b0;
    int           hold_requests = 0;
    int           hold_seen = 0;
    int           hold_left = 0;

    ray_obb_slab_intersect dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard limit on run time.
    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Rotate one vector by a packed column and round to Q16.16, half up.
    function automatic longint rot_dot(longint a, longint b, longint c, logic [47:0] col);
        longint r0, r1, r2, acc;
        r0 = $signed(col[15:0]);
        r1 = $signed(col[31:16]);
        r2 = $signed(col[47:32]);
        acc = a * r0 + b * r1 + c * r2;
        return (acc + 8192) >>> 14;
    endfunction

    function automatic longint sat_q16(longint v);
        if (v < -64'sd2147483648) return -64'sd2147483648;
        if (v > 64'sd2147483647) return 64'sd2147483647;
        return v;
    endfunction

    // Clip the interval against one slab; zero means the box is rejected.
    function automatic bit clip_slab(longint lo, longint ld, longint ext,
                                     inout longint tmin, inout longint tmax);
        longint t1, t2;
        if (ld == 0) begin
            return ((2 * lo < 0) ? -2 * lo : 2 * lo) <= ext;
        end
        t1 = sat_q16(((-ext - 2 * lo) * 32768) / ld);
        t2 = sat_q16(((ext - 2 * lo) * 32768) / ld);
        if (t1 > t2) begin
            t1 = t1 ^ t2;
            t2 = t1 ^ t2;
            t1 = t1 ^ t2;
        end
        if (t1 > tmin) tmin = t1;
        if (t2 < tmax) tmax = t2;
        return 1'b1;
    endfunction

    // Expected {entry_distance, hit} for one box under the current ray.
    function automatic logic [32:0] slab_predict(t_box b);
        longint      rx, ry, rz, dx, dy, dz, tmin, tmax, lo, ld;
        longint      ext [3];
        logic [47:0] col [3];
        bit          ok;
        rx = longint'($signed(ray_reg[0])) - longint'($signed(b.cx));
        ry = longint'($signed(ray_reg[1])) - longint'($signed(b.cy));
        rz = longint'($signed(ray_reg[2])) - longint'($signed(b.cz));
        dx = $signed(ray_reg[3]);
        dy = $signed(ray_reg[4]);
        dz = $signed(ray_reg[5]);
        col[0] = b.ax; col[1] = b.ay; col[2] = b.az;
        ext[0] = {33'd0, b.ex}; ext[1] = {33'd0, b.ey}; ext[2] = {33'd0, b.ez};
        tmin = -64'sd2147483648;
        tmax = 64'sd2147483647;
        ok = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (ok) begin
                lo = rot_dot(rx, ry, rz, col[i]);
                ld = rot_dot(dx, dy, dz, col[i]);
                ok = clip_slab(lo, ld, ext[i], tmin, tmax);
            end
        end
        if (ok && (tmax < 0 || tmin > tmax)) ok = 1'b0;
        return ok ? {tmin[31:0], 1'b1} : 33'd0;
    endfunction

    function automatic logic [47:0] col3(int a, int b, int c);
        return {c[15:0], b[15:0], a[15:0]};
    endfunction

    function automatic t_box make_box(int cx, int cy, int cz, int ex, int ey, int ez);
        t_box b;
        b.cx = cx; b.cy = cy; b.cz = cz;
        b.ax = col3(ROT_ONE, 0, 0);
        b.ay = col3(0, ROT_ONE, 0);
        b.az = col3(0, 0, ROT_ONE);
        b.ex = ex[30:0]; b.ey = ey[30:0]; b.ez = ez[30:0];
        return b;
    endfunction

    function automatic t_box noise_box();
        t_box b;
        b.cx = $urandom; b.cy = $urandom; b.cz = $urandom;
        b.ax = 48'({$urandom, $urandom}); b.ay = 48'({$urandom, $urandom});
        b.az = 48'({$urandom, $urandom});
        b.ex = 31'($urandom); b.ey = 31'($urandom); b.ez = 31'($urandom);
        return b;
    endfunction

    // A box near the ray origin, mostly with a signed axis permutation as rotation.
    function automatic t_box near_box();
        t_box b;
        int   m [9];
        int   perm [3];
        int   k;
        b.cx = ray_reg[0] + $urandom_range(0, 32 * ONE) - 16 * ONE;
        b.cy = ray_reg[1] + $urandom_range(0, 8 * ONE) - 4 * ONE;
        b.cz = ray_reg[2] + $urandom_range(0, 8 * ONE) - 4 * ONE;
        if ($urandom_range(0, 99) < 70) begin
            perm[0] = 0; perm[1] = 1; perm[2] = 2;
            k = $urandom_range(0, 2);
            perm[k] = perm[0];
            perm[0] = k;
            if ($urandom_range(0, 1)) begin
                k = perm[1]; perm[1] = perm[2]; perm[2] = k;
            end
            for (int i = 0; i < 9; i++) m[i] = 0;
            for (int r = 0; r < 3; r++) begin
                m[3 * r + perm[r]] = $urandom_range(0, 1) ? ROT_ONE : -ROT_ONE;
            end
        end else begin
            for (int i = 0; i < 9; i++) m[i] = $urandom_range(0, 2 * ROT_ONE) - ROT_ONE;
        end
        b.ax = col3(m[0], m[3], m[6]);
        b.ay = col3(m[1], m[4], m[7]);
        b.az = col3(m[2], m[5], m[8]);
        b.ex = 31'($urandom_range(0, 12 * ONE));
        b.ey = 31'($urandom_range(0, 12 * ONE));
        b.ez = 31'($urandom_range(0, 12 * ONE));
        return b;
    endfunction

    // Offer one box and wait for its beat to be taken.
    task automatic send_box(t_box b);
        while (!quiet && $urandom_range(0, 99) < 12) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= {3'b000, b.ez, b.ey, b.ex, b.az, b.ay, b.ax, b.cz, b.cy, b.cx};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_hits = {pending_hits, slab_predict(b)};
    endtask

    // Stop offering and wait until every result is in and the pipeline is empty.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CY) @(posedge i_clk);
    endtask

    // Write all six ray registers on consecutive cycles; the block must be idle.
    task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        logic [31:0] vals [6];
        logic [2:0]  idx [6];
        vals[0] = ox; vals[1] = oy; vals[2] = oz;
        vals[3] = dx; vals[4] = dy; vals[5] = dz;
        idx[0] = rosi_pkg::REG_ORIGIN_X;
        idx[1] = rosi_pkg::REG_ORIGIN_Y;
        idx[2] = rosi_pkg::REG_ORIGIN_Z;
        idx[3] = rosi_pkg::REG_DIR_X;
        idx[4] = rosi_pkg::REG_DIR_Y;
        idx[5] = rosi_pkg::REG_DIR_Z;
        for (int i = 0; i < 6; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= idx[i];
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
            ray_reg[idx[i]] = vals[i];
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reset ray along +x: front, behind, off to the side, around the origin, degenerate boxes.
    task automatic test_reset_ray();
        t_box b;
        send_box(make_box(5 * ONE, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE));
        send_box(make_box(-5 * ONE, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE));
        send_box(make_box(5 * ONE, 3 * ONE, 0, 2 * ONE, 2 * ONE, 2 * ONE));
        send_box(make_box(0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE));
        send_box(make_box(5 * ONE, 0, 0, 0, 0, 0));
        b = make_box(0, 0, 0, 0, 0, 0);
        b.ax = '0; b.ay = '0; b.az = '0;
        send_box(b);                                   // every axis parallel, origin on the box
        b.ex = 1;
        send_box(b);
        b = noise_box();
        b.cx = '0; b.cy = '0; b.cz = '0; b.ax = '0; b.ay = '0; b.az = '0;
        b.ex = '0; b.ey = '0; b.ez = '0;
        send_box(b);
        b.cx = '1; b.cy = '1; b.cz = '1; b.ax = '1; b.ay = '1; b.az = '1;
        b.ex = '1; b.ey = '1; b.ez = '1;
        send_box(b);
        b = make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, '1, '1);
        send_box(b);
        b = make_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1, '1);
        b.ax = col3(-32768, 32767, -32768);
        send_box(b);
        drain();
    endtask

    // Diagonal ray: entry after exit, and a hit through a corner region.
    task automatic test_diagonal();
        set_ray(0, 0, 0, 46341, 46341, 0);
        send_box(make_box(5 * ONE, 2 * ONE, 0, 2 * ONE, 2 * ONE, 2 * ONE));
        send_box(make_box(5 * ONE, 5 * ONE, 0, 2 * ONE, 2 * ONE, 2 * ONE));
        send_box(make_box(5 * ONE, -5 * ONE, 0, 2 * ONE, 2 * ONE, 2 * ONE));
        drain();
    endtask

    // Tiny direction and huge boxes force the slab distances to saturate.
    task automatic test_saturation();
        set_ray(0, 0, 0, 1, 0, 0);
        send_box(make_box(0, 0, 0, '1, '1, '1));
        send_box(make_box(100 * ONE, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE));
        send_box(make_box(32'h7FFF_FFFF, 0, 0, '1, 4 * ONE, 4 * ONE));
        drain();
    endtask

    // Register extremes with a few structured and random boxes.
    task automatic test_extreme_regs();
        set_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_box(make_box(0, 0, 0, '1, '1, '1));
        send_box(noise_box());
        drain();
        set_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_box(make_box(0, 0, 0, '1, '1, '1));
        send_box(noise_box());
        drain();
    endtask

    // One random ray per phase, then mostly boxes near it with some noise.
    task automatic test_random_phase(int count, bit with_hold);
        logic [31:0] d [3];
        int          sel;
        sel = $urandom_range(0, 3);
        for (int i = 0; i < 3; i++) d[i] = 0;
        case (sel)
            0: d[$urandom_range(0, 2)] = $urandom_range(0, 1) ? ONE : -ONE;
            1: begin
                d[0] = $urandom_range(0, 1) ? 46341 : -46341;
                d[$urandom_range(1, 2)] = $urandom_range(0, 1) ? 46341 : -46341;
            end
            2: for (int i = 0; i < 3; i++) d[i] = $urandom_range(0, 2 * ONE) - ONE;
            default: for (int i = 0; i < 3; i++) d[i] = $urandom;
        endcase
        set_ray($urandom_range(0, 200 * ONE) - 100 * ONE,
                $urandom_range(0, 200 * ONE) - 100 * ONE,
                $urandom_range(0, 200 * ONE) - 100 * ONE, d[0], d[1], d[2]);
        for (int n = 0; n < count; n++) begin
            if (with_hold && n == 20) begin
                quiet = 1'b1;
                hold_requests++;
            end
            if (n == count / 2) quiet = 1'b0;
            if ($urandom_range(0, 99) < 15) send_box(noise_box());
            else send_box(near_box());
        end
        quiet = 1'b0;
        drain();
    endtask

    // Compare each result beat with the oldest expectation.
    always @(posedge i_clk) begin
        logic [32:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_hits.size() == 0) begin
                $display("%0t: result beat with nothing expected, got hit=%0b dist=%h",
                         $time, m_axis_tdata[0], m_axis_tdata[32:1]);
                errors++;
            end else begin
                want = pending_hits.pop_front();
                if (m_axis_tdata[0] !== want[0]) begin
                    $display("%0t: hit expected %0b actual %0b", $time, want[0], m_axis_tdata[0]);
                    errors++;
                end
                if (m_axis_tdata[32:1] !== want[32:1]) begin
                    $display("%0t: entry_distance expected %h actual %h",
                             $time, want[32:1], m_axis_tdata[32:1]);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_requests) begin
            hold_seen     <= hold_requests;
            hold_left     <= HOLD_CY;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= 12);
        end
    end

    initial begin
        ray_reg[0] = 0; ray_reg[1] = 0; ray_reg[2] = 0;
        ray_reg[3] = rosi_pkg::DIR_X_RESET; ray_reg[4] = 0; ray_reg[5] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_ray();
        test_diagonal();
        test_saturation();
        test_extreme_regs();
        test_random_phase(240, 1'b1);
        for (int p = 0; p < 4; p++) test_random_phase(240, 1'b0);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
